[design/tlpq_pkg.sv]
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared types and constants for the three-level priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

   localparam int DEPTH = 16;

   typedef enum logic [1:0] {
      MODE_PUT   = 2'd0,
      MODE_GET   = 2'd1,
      MODE_ACCEL = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   localparam logic [1:0] LVL_LOW    = 2'd0;
   localparam logic [1:0] LVL_NORMAL = 2'd1;
   localparam logic [1:0] LVL_HIGH   = 2'd2;

   typedef struct packed {
      logic        valid;
      logic [31:0] payload;
      logic [1:0]  level;
   } entry_type;

   typedef struct packed {
      logic        do_put;
      logic        do_get;
      logic        do_accel;
      logic [1:0]  target;
      logic [31:0] payload;
      logic [1:0]  level;
   } cmd_type;

   typedef struct packed {
      logic any_high;
      logic any_normal;
      logic any_low;
   } scan_type;

endpackage

[design/tlpq_cell.sv]
// ----------------------------------------------------------------------------
// tlpq_cell
// One queue slot: holds an entry, joins the level scan and the removal chain,
// and takes its successor's entry when an entry at or before it is removed.
// ----------------------------------------------------------------------------
module tlpq_cell
   import tlpq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      prev_valid,
   input  entry_type next_entry,
   input  scan_type  scan_in,
   output scan_type  scan_out,
   input  logic      hit_in,
   output logic      hit_out,
   input  entry_type sel_in,
   output entry_type sel_out,
   output entry_type entry_out
);

   logic        valid_ff, valid_in;
   logic [31:0] payload_ff, payload_in;
   logic [1:0]  level_ff, level_in;
   logic        hit, shift, put_here;

   always_comb begin
      scan_out.any_high   = scan_in.any_high   | (valid_ff && level_ff == LVL_HIGH);
      scan_out.any_normal = scan_in.any_normal | (valid_ff && level_ff == LVL_NORMAL);
      scan_out.any_low    = scan_in.any_low    | (valid_ff && level_ff == LVL_LOW);
   end

   assign hit      = cmd.do_get && valid_ff && (level_ff == cmd.target) && !hit_in;
   assign hit_out  = hit_in | hit;
   assign shift    = cmd.do_get && hit_out;
   assign put_here = cmd.do_put && !valid_ff && prev_valid;

   assign entry_out.valid   = valid_ff;
   assign entry_out.payload = payload_ff;
   assign entry_out.level   = level_ff;
   assign sel_out = hit ? entry_out : sel_in;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      level_in   = level_ff;
      if (shift) begin
         valid_in   = next_entry.valid;
         payload_in = next_entry.payload;
         level_in   = next_entry.level;
      end else if (put_here) begin
         valid_in   = 1'b1;
         payload_in = cmd.payload;
         level_in   = cmd.level;
      end else if (cmd.do_accel && valid_ff && level_ff == LVL_LOW) begin
         level_in   = LVL_HIGH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      level_ff   <= level_in;
   end

endmodule

[design/three_level_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// Response: the result beat is registered and appears the cycle after accept.
// Throughput: one item per cycle while rsp_tready is not held low against a
// pending beat; the path is the level scan and removal chain through the DEPTH cells.
// Reset: synchronous; clears every cell's valid bit, leaving the queue empty.
// ----------------------------------------------------------------------------
// three_level_priority_queue_core
// Priority queue of DEPTH cells in arrival order with low, normal and high
// levels; put, get oldest of highest level, accelerate low to high.
// ----------------------------------------------------------------------------
module three_level_priority_queue_core
   import tlpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // payload[31:0], level[33:32], zero pad
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // out_payload[31:0], out_level[33:32], zero pad
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   logic            go;
   mode_type        mode;
   logic [1:0]      req_level;
   cmd_type         cmd;
   logic [DEPTH-1:0] valid_vec;
   logic            full, empty;

   scan_type  scan_chain [DEPTH+1];
   logic      hit_chain  [DEPTH+1];
   entry_type sel_chain  [DEPTH+1];
   entry_type entries    [DEPTH+1];

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [31:0] payload_ff, payload_in;
   logic [1:0]  level_ff, level_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign go         = req_tvalid && req_tready;
   assign mode       = mode_type'(req_tuser);
   assign req_level  = (req_tdata[33:32] == 2'd3) ? LVL_HIGH : req_tdata[33:32];

   assign full  = valid_vec[DEPTH-1];
   assign empty = !valid_vec[0];

   always_comb begin
      cmd.do_put   = go && mode == MODE_PUT;
      cmd.do_get   = go && mode == MODE_GET;
      cmd.do_accel = go && mode == MODE_ACCEL;
      cmd.payload  = req_tdata[31:0];
      cmd.level    = req_level;
      if (scan_chain[DEPTH].any_high) begin
         cmd.target = LVL_HIGH;
      end else if (scan_chain[DEPTH].any_normal) begin
         cmd.target = LVL_NORMAL;
      end else begin
         cmd.target = LVL_LOW;
      end
   end

   assign scan_chain[0] = '0;
   assign hit_chain[0]  = 1'b0;
   assign sel_chain[0]  = '0;
   assign entries[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      tlpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_valid ((i == 0) ? 1'b1 : entries[(i == 0) ? 0 : i-1].valid),
         .next_entry (entries[i+1]),
         .scan_in    (scan_chain[i]),
         .scan_out   (scan_chain[i+1]),
         .hit_in     (hit_chain[i]),
         .hit_out    (hit_chain[i+1]),
         .sel_in     (sel_chain[i]),
         .sel_out    (sel_chain[i+1]),
         .entry_out  (entries[i])
      );
      assign valid_vec[i] = entries[i].valid;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      payload_in   = payload_ff;
      level_in     = level_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_DONE;
         payload_in   = '0;
         level_in     = LVL_LOW;
         case (mode)
            MODE_PUT: begin
               if (full) status_in = ST_FULL;
            end
            MODE_GET: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  payload_in = sel_chain[DEPTH].payload;
                  level_in   = sel_chain[DEPTH].level;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      payload_ff <= payload_in;
      level_ff   <= level_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {6'd0, level_ff, payload_ff};

   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + 1'b1) & valid_vec) == '0)
      else $error("queue cells not filled from the head");

   a_put_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_put && full) |=> (rsp_tuser == ST_FULL && $stable(valid_vec)))
      else $error("put on full queue not rejected");

   a_get_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_get && empty) |=> (rsp_tuser == ST_EMPTY))
      else $error("get on empty queue not flagged");

   a_get_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_get && !empty) |=>
         ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
      else $error("get did not remove exactly one entry");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for three_level_priority_queue_core. Items go in on the
// req stream in bursts with random gaps; a shadow copy of the queue predicts
// every response beat, and each beat is compared field by field in order.
// Directed items cover the empty, no-op, saturating-level, priority-order and
// accelerate cases, then random fill to full, drain and mixed runs follow under random back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tlpq_pkg::*;

   localparam logic [1:0] LVL_SPARE = 2'd3;
   localparam int ITEM_TARGET = 1600;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER = 500;

   typedef struct {
      status_type  status;
      logic [31:0] payload;
      logic [1:0]  level;
   } reply_type;

   class priority_queue_mirror;
      logic [31:0] stored_payload[$];
      logic [1:0]  stored_level[$];
      reply_type   replies[$];
      int          failures = 0;

      function int occupancy();
         return stored_payload.size();
      endfunction

      function int outstanding();
         return replies.size();
      endfunction

      function void apply_request(mode_type mode, logic [31:0] payload, logic [1:0] level);
         reply_type r;
         int pos;
         int lv;
         r.status  = ST_DONE;
         r.payload = '0;
         r.level   = LVL_LOW;
         case (mode)
            MODE_PUT: begin
               if (stored_payload.size() >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  stored_payload.insert(stored_payload.size(), payload);
                  stored_level.insert(stored_level.size(),
                                      (level == LVL_SPARE) ? LVL_HIGH : level);
               end
            end
            MODE_GET: begin
               if (stored_payload.size() == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  pos = -1;
                  for (lv = int'(LVL_HIGH); lv >= int'(LVL_LOW) && pos < 0; lv--)
                     for (int i = 0; i < stored_level.size() && pos < 0; i++)
                        if (stored_level[i] == lv) pos = i;
                  r.payload = stored_payload[pos];
                  r.level   = stored_level[pos];
                  stored_payload.delete(pos);
                  stored_level.delete(pos);
               end
            end
            MODE_ACCEL: begin
               foreach (stored_level[i])
                  if (stored_level[i] == LVL_LOW) stored_level[i] = LVL_HIGH;
            end
            default: ;
         endcase
         replies.insert(replies.size(), r);
      endfunction

      function void check_response(logic [1:0] status, logic [31:0] payload, logic [1:0] level);
         reply_type r;
         if (replies.size() == 0) begin
            $error("response beat with nothing outstanding: status %0d payload %h level %0d",
                   status, payload, level);
            failures++;
            return;
         end
         r = replies.pop_front();
         if (status !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, status);
            failures++;
         end
         if (payload !== r.payload) begin
            $error("out_payload: expected %h, got %h", r.payload, payload);
            failures++;
         end
         if (level !== r.level) begin
            $error("out_level: expected %0d, got %0d", r.level, level);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // payload[31:0], level[33:32], zero pad
   logic [1:0]  req_tuser = MODE_NOP;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;   // out_payload[31:0], out_level[33:32], zero pad
   logic [1:0]  rsp_tuser;   // status[1:0]

   priority_queue_mirror mirror = new();
   int items_sent = 0;
   int burst_left = 0;
   int responses_seen = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_pct = 0;
   int stall_phase = 0;
   int idle_cycles = 0;

   three_level_priority_queue_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function logic [1:0] random_level();
      return ($urandom_range(0, 9) == 0) ? LVL_SPARE : 2'($urandom_range(0, 2));
   endfunction

   function mode_type random_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return MODE_PUT;
      if (r < 85) return MODE_GET;
      if (r < 95) return MODE_ACCEL;
      return MODE_NOP;
   endfunction

   // one beat on the req stream; valid only drops at the end of a burst
   task automatic offer_item(mode_type mode, logic [31:0] payload, logic [1:0] level);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, level, payload};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mirror.apply_request(mode, payload, level);
      items_sent++;
      burst_left--;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         mirror.check_response(rsp_tuser, rsp_tdata[31:0], rsp_tdata[33:32]);
         responses_seen++;
      end
      if (stall_phase == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
         stall_phase = $urandom_range(20, 80);
      end else begin
         stall_phase--;
      end
      if (!hold_done && responses_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, no-op, saturating level, priority order, accelerate
      offer_item(MODE_GET,   32'h0000_0000, LVL_LOW);
      offer_item(MODE_ACCEL, 32'hFFFF_FFFF, LVL_SPARE);
      offer_item(MODE_NOP,   32'hFFFF_FFFF, LVL_SPARE);
      offer_item(MODE_PUT,   32'h0000_0000, LVL_LOW);
      offer_item(MODE_PUT,   32'hFFFF_FFFF, LVL_NORMAL);
      offer_item(MODE_PUT,   32'h8000_0001, LVL_SPARE);
      offer_item(MODE_PUT,   32'h0000_0001, LVL_LOW);
      offer_item(MODE_PUT,   32'h7FFF_FFFE, LVL_HIGH);
      offer_item(MODE_PUT,   32'h5555_AAAA, LVL_NORMAL);
      offer_item(MODE_GET,   32'h0000_0000, LVL_LOW);
      offer_item(MODE_GET,   32'h0000_0000, LVL_LOW);
      offer_item(MODE_ACCEL, 32'h0000_0000, LVL_LOW);
      offer_item(MODE_GET,   32'h0000_0000, LVL_LOW);
      offer_item(MODE_GET,   32'h0000_0000, LVL_LOW);
      offer_item(MODE_GET,   32'h0000_0000, LVL_LOW);
      offer_item(MODE_GET,   32'h0000_0000, LVL_LOW);
      offer_item(MODE_PUT,   32'h1234_5678, LVL_LOW);
      offer_item(MODE_PUT,   32'h0F0F_0F0F, LVL_NORMAL);
      offer_item(MODE_GET,   32'hFFFF_FFFF, LVL_SPARE);
      offer_item(MODE_GET,   32'hFFFF_FFFF, LVL_SPARE);
      offer_item(MODE_GET,   32'hFFFF_FFFF, LVL_SPARE);
      offer_item(MODE_NOP,   32'h0000_0000, LVL_LOW);

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // fill to full and a little past it
               n = DEPTH - mirror.occupancy() + $urandom_range(0, 2);
               repeat (n) offer_item(MODE_PUT, $urandom, random_level());
            end
            3, 4: begin
               // drain to empty and a little past it
               n = mirror.occupancy() + $urandom_range(0, 2);
               repeat (n) offer_item(MODE_GET, $urandom, random_level());
            end
            9: begin
               repeat ($urandom_range(1, 6))
                  offer_item(MODE_PUT, $urandom, 2'($urandom_range(0, 1)));
               offer_item(MODE_ACCEL, $urandom, random_level());
               repeat ($urandom_range(1, 4)) offer_item(MODE_GET, $urandom, random_level());
            end
            default: begin
               repeat ($urandom_range(8, 40))
                  offer_item(random_mode(), $urandom, random_level());
            end
         endcase
      end

      req_tvalid <= 1'b0;
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mirror.failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
design/tlpq_pkg.sv
design/tlpq_cell.sv
design/three_level_priority_queue_core.sv
tb/sv/testbench.sv
